/* sv/pdc_pkg.sv */
// pdc_pkg: shared types, widths, constants and the 32-bit saturation helper
// for the pid duty controller; no dependencies
`default_nettype none

package pdc_pkg;

    localparam int GAIN_W  = 32;
    localparam int ALPHA_W = 17;
    localparam int ERR_W   = 17;
    localparam int DERR_W  = 18;
    localparam int MB_W    = 18;
    localparam int PROD_W  = 50;
    localparam int UP_W    = 49;
    localparam int ACC_W   = 51;
    localparam int DUTY_W  = 7;

    localparam int ALPHA_BITS = 16;
    localparam int ALPHA_ONE  = 65536;
    localparam int DUTY_MAX   = 100;

    typedef enum logic [1:0] {
        CFG_KP    = 2'd0,
        CFG_KI    = 2'd1,
        CFG_KD    = 2'd2,
        CFG_ALPHA = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] setpoint;
        logic signed [15:0] measurement;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        channel_out;
        logic [DUTY_W-1:0] duty;
    } t_out_word;

    // per-channel controller state
    typedef struct packed {
        logic signed [ERR_W-1:0]  prev_error;
        logic signed [GAIN_W-1:0] integral_term;
        logic signed [GAIN_W-1:0] filtered_derivative;
    } t_chan_rec;

    function automatic logic signed [GAIN_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [GAIN_W-1:0] r;
        if ((&x[ACC_W-1:GAIN_W-1]) || !(|x[ACC_W-1:GAIN_W-1])) begin
            r = x[GAIN_W-1:0];
        end else if (x[ACC_W-1]) begin
            r = {1'b1, {(GAIN_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(GAIN_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/pdc_alu.sv */
// pdc_alu: the shared arithmetic unit, a registered 32x18 signed multiplier
// and a 51-bit adder; uses pdc_pkg
`default_nettype none

module pdc_alu (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_mul_en,
    input  wire logic signed [pdc_pkg::GAIN_W-1:0]    i_mul_a,
    input  wire logic signed [pdc_pkg::MB_W-1:0]      i_mul_b,
    input  wire logic signed [pdc_pkg::ACC_W-1:0]     i_add_a,
    input  wire logic signed [pdc_pkg::ACC_W-1:0]     i_add_b,
    output logic signed [pdc_pkg::PROD_W-1:0]         o_prod,
    output logic signed [pdc_pkg::ACC_W-1:0]          o_sum
);
    import pdc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= PROD_W'(i_mul_a) * PROD_W'(i_mul_b);
        end
    end

    assign o_prod = r_prod;
    assign o_sum  = i_add_a + i_add_b;

endmodule

`default_nettype wire

/* sv/pdc_bank.sv */
// pdc_bank: per-channel state registers (previous error, integral, filtered
// derivative), cleared by reset; uses pdc_pkg
`default_nettype none

module pdc_bank #(
    parameter int  CHANNELS = 3,
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [IDX_W-1:0]      i_rd_idx,
    input  wire logic                  i_wr_en,
    input  wire logic [IDX_W-1:0]      i_wr_idx,
    input  wire pdc_pkg::t_chan_rec    i_wr_rec,
    output pdc_pkg::t_chan_rec         o_rd_rec
);
    import pdc_pkg::*;

    t_chan_rec r_rec [CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_rec[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_rec[i_wr_idx] <= i_wr_rec;
        end
    end

    // an index with no channel behind it reads as all zeros
    always_comb begin
        o_rd_rec = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (i_rd_idx == IDX_W'(i)) begin
                o_rd_rec = r_rec[i];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/pid_duty_controller_unit.sv */
// pid_duty_controller_unit: top level, sequencer around the shared arithmetic
// unit; uses pdc_pkg, pdc_alu and pdc_bank
//
// usage: input channel i_in_valid / o_in_stall / i_in_word (channel, setpoint,
//   measurement), a word is taken at a rising edge with valid high and stall
//   low. output channel o_out_valid / i_out_stall / o_out_word (channel_out,
//   duty), one result word per input word, in order. i_cfg_we with
//   i_cfg_index and i_cfg_data writes kp, ki*ts, kd/ts (signed Q.FRAC_BITS)
//   and the Q1.16 filter weight; write only while the block is idle.
// schedule: 11 busy steps, then a return to idle before the next acceptance;
//   the multiplier is used five times and the 51-bit adder six times, at
//   most one of each per step. a channel number at or above CHANNELS skips
//   the arithmetic, goes straight to the last step, gives duty 0 and changes
//   no state.
// reset: synchronous, active low: gains clear, the filter weight goes to one,
//   all channel state clears, both channels go empty.
// back-pressure: the result sits in an output register; a new input word is
//   taken while it waits. a finished word waits in its last step until that
//   register frees.
`default_nettype none

module pid_duty_controller_unit #(
    parameter int CHANNELS  = 3,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire pdc_pkg::t_in_word              i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output pdc_pkg::t_out_word                  o_out_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [pdc_pkg::GAIN_W-1:0]     i_cfg_data
);
    import pdc_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic signed [ACC_W-1:0] HUNDRED = ACC_W'(DUTY_MAX) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MP, S_MD, S_MF1, S_MF2, S_FLT, S_UDF, S_U, S_I, S_S1, S_S2, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic signed [GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic [ALPHA_W-1:0]       r_alpha;

    // working registers
    logic [1:0]               r_chan;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_in_range;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [GAIN_W-1:0] r_integ;
    logic signed [GAIN_W-1:0] r_udf;
    logic signed [GAIN_W-1:0] r_ud;
    logic signed [UP_W-1:0]   r_up;
    logic signed [ACC_W-1:0]  r_acc;

    logic      r_out_valid;
    t_out_word r_out_word;

    // channel decode
    logic [IDX_W+1:0] ch_ext;
    logic [IDX_W-1:0] in_idx;
    logic             in_range;

    assign ch_ext   = {{IDX_W{1'b0}}, i_in_word.channel};
    assign in_idx   = ch_ext[IDX_W-1:0];
    assign in_range = ch_ext < (IDX_W+2)'(CHANNELS);

    t_chan_rec rd_rec, wr_rec;
    logic      bank_we;
    logic      in_acc;
    logic      out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign bank_we  = (r_state == S_DONE) && out_free && r_in_range;

    assign wr_rec.prev_error          = r_err;
    assign wr_rec.integral_term       = r_integ;
    assign wr_rec.filtered_derivative = r_udf;

    pdc_bank #(
        .CHANNELS(CHANNELS)
    ) u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (in_idx),
        .i_wr_en  (bank_we),
        .i_wr_idx (r_idx),
        .i_wr_rec (wr_rec),
        .o_rd_rec (rd_rec)
    );

    // filter weight, anything above one acts as one
    logic [ALPHA_W-1:0] a_sat, a_inv;
    assign a_sat = (r_alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : r_alpha;
    assign a_inv = ALPHA_W'(ALPHA_ONE) - a_sat;

    logic signed [DERR_W-1:0] derr;
    assign derr = DERR_W'(r_err) - DERR_W'(r_prev);

    // operand selection for the shared unit
    logic                     mul_en;
    logic signed [GAIN_W-1:0] mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]  add_a, add_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  sum;

    always_comb begin
        mul_en = 1'b1;
        mul_a  = r_kp;
        mul_b  = MB_W'(r_err);
        add_a  = r_acc;
        add_b  = ACC_W'(prod);
        unique case (r_state)
            S_MP: begin
                mul_a = r_kp;
                mul_b = MB_W'(r_err);
            end
            S_MD: begin
                mul_a = r_kd;
                mul_b = derr;
            end
            S_MF1: begin
                // (one - a) times the old filtered derivative
                mul_a = r_udf;
                mul_b = signed'({1'b0, a_inv});
            end
            S_MF2: begin
                mul_a = r_ud;
                mul_b = signed'({1'b0, a_sat});
            end
            S_FLT: begin
                // filter sum, and ki*ts times error for later
                mul_a = r_ki;
                mul_b = MB_W'(r_err);
                add_a = r_acc;
                add_b = ACC_W'(prod);
            end
            S_UDF, S_S1: begin
                mul_en = 1'b0;
                add_a  = ACC_W'(r_up);
                add_b  = ACC_W'(r_integ);
            end
            S_U, S_S2: begin
                mul_en = 1'b0;
                add_a  = r_acc;
                add_b  = ACC_W'(r_udf);
            end
            S_I: begin
                mul_en = 1'b0;
                add_a  = ACC_W'(r_integ);
                add_b  = ACC_W'(prod);
            end
            S_IDLE, S_DONE: begin
                mul_en = 1'b0;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    pdc_alu u_alu (
        .i_clk    (i_clk),
        .i_mul_en (mul_en),
        .i_mul_a  (mul_a),
        .i_mul_b  (mul_b),
        .i_add_a  (add_a),
        .i_add_b  (add_b),
        .o_prod   (prod),
        .o_sum    (sum)
    );

    // conditional anti-windup: hold while pushing further into a rail
    logic err_pos, err_neg, hold;
    assign err_pos = !r_err[ERR_W-1] && (r_err != '0);
    assign err_neg = r_err[ERR_W-1];
    assign hold    = ((r_acc >= HUNDRED) && err_pos)
                     || ((r_acc[ACC_W-1] || (r_acc == '0)) && err_neg);

    // duty from the final sum, truncated toward zero and clamped
    logic [DUTY_W-1:0] duty;
    always_comb begin
        if (r_acc[ACC_W-1] || (r_acc == '0)) begin
            duty = '0;
        end else if (r_acc >= HUNDRED) begin
            duty = DUTY_W'(DUTY_MAX);
        end else begin
            duty = r_acc[FRAC_BITS+DUTY_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_alpha     <= ALPHA_W'(ALPHA_ONE);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KP:    r_kp    <= i_cfg_data;
                    CFG_KI:    r_ki    <= i_cfg_data;
                    CFG_KD:    r_kd    <= i_cfg_data;
                    CFG_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                    default:   ;
                endcase
            end

            // the last step refills the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_chan     <= i_in_word.channel;
                        r_idx      <= in_idx;
                        r_in_range <= in_range;
                        r_err      <= ERR_W'(i_in_word.setpoint)
                                      - ERR_W'(i_in_word.measurement);
                        r_prev     <= rd_rec.prev_error;
                        r_integ    <= rd_rec.integral_term;
                        r_udf      <= rd_rec.filtered_derivative;
                        r_acc      <= '0;
                        r_state    <= in_range ? S_MP : S_DONE;
                    end
                end
                S_MP: r_state <= S_MD;
                S_MD: begin
                    r_up    <= prod[UP_W-1:0];
                    r_state <= S_MF1;
                end
                S_MF1: begin
                    r_ud    <= sat32(ACC_W'(prod));
                    r_state <= S_MF2;
                end
                S_MF2: begin
                    r_acc   <= ACC_W'(prod);
                    r_state <= S_FLT;
                end
                S_FLT: begin
                    r_acc   <= sum;
                    r_state <= S_UDF;
                end
                S_UDF: begin
                    // floor of the weighted sum by one in Q1.16
                    r_udf   <= sat32(r_acc >>> ALPHA_BITS);
                    r_acc   <= sum;
                    r_state <= S_U;
                end
                S_U: begin
                    r_acc   <= sum;
                    r_state <= S_I;
                end
                S_I: begin
                    if (!hold) begin
                        r_integ <= sat32(sum);
                    end
                    r_state <= S_S1;
                end
                S_S1: begin
                    r_acc   <= sum;
                    r_state <= S_S2;
                end
                S_S2: begin
                    r_acc   <= sum;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_word.channel_out <= r_chan;
                        r_out_word.duty        <= duty;
                        r_state                <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

/* sv/pdc_checker.sv */
// pdc_checker: port-level assertions for pid_duty_controller_unit and the
// bind that attaches them; uses pdc_pkg
`default_nettype none

module pdc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire pdc_pkg::t_out_word          o_out_word
);
    import pdc_pkg::*;

    // reset leaves both channels empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("not empty after reset");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while busy");

    // a result only comes out of a working sequencer
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.duty <= DUTY_W'(DUTY_MAX)))
        else $error("duty above full scale");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

endmodule

bind pid_duty_controller_unit pdc_checker u_pdc_checker (.*);

`default_nettype wire

/* test/tb_pid_duty_controller_unit.sv */
// tb_pid_duty_controller_unit: self-checking bench for the per-channel pid duty block
// depends on pdc_pkg and pid_duty_controller_unit; a directed table runs first, then
// randomized gain settings and words, each result checked against a predictor or typed duty
`timescale 1ns / 100ps

module tb_pid_duty_controller_unit;
    import pdc_pkg::*;

    localparam int     CHAN_COUNT  = 3;
    localparam int     FRAC        = 16;
    localparam longint FULL_SCALE  = longint'(DUTY_MAX) << FRAC;
    localparam longint S32_MAX     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN     = -64'sh0000_0000_8000_0000;
    localparam int     NO_WANT     = -1;
    localparam int     PHASES      = 6;
    localparam int     PHASE_WORDS = 255;
    // longest stretch with no word moving on either side before the run is called hung;
    // well above the long receiver hold plus the compute of one word
    localparam int     QUIET_LIMIT = 2000;
    localparam int     HOLD_CYCLES = 400;
    localparam int     TAIL_CYCLES = 24;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;
    typedef enum int {GAINS_EDGE, GAINS_WIDE, GAINS_TUNED} t_gain_style;

    // one directed step: either a word to send or a register to write
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  channel;
        logic [15:0] setpoint;
        logic [15:0] measurement;
        t_cfg_index  reg_sel;
        logic [31:0] reg_data;
        int          want;
    } t_step_row;

    localparam int DIR_ROWS = 36;
    localparam t_step_row DIR_TABLE [DIR_ROWS] = '{
        // gains still at reset: every duty is zero, extremes and the unused channel too
        '{ROW_WORD, 2'd0, 16'h7FFF, 16'h8000, CFG_KP,    32'h0000_0000, 0},
        '{ROW_WORD, 2'd1, 16'h8000, 16'h7FFF, CFG_KP,    32'h0000_0000, 0},
        '{ROW_WORD, 2'd2, 16'h0000, 16'h0000, CFG_KP,    32'h0000_0000, 0},
        '{ROW_WORD, 2'd3, 16'h0064, 16'h0000, CFG_KP,    32'h0000_0000, 0},
        // pure proportional, gain one
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KP,    32'h0001_0000, NO_WANT},
        '{ROW_WORD, 2'd0, 16'h0032, 16'h0000, CFG_KP,    32'h0000_0000, 50},
        '{ROW_WORD, 2'd1, 16'h0000, 16'h00C8, CFG_KP,    32'h0000_0000, 0},
        '{ROW_WORD, 2'd2, 16'h03E8, 16'h0000, CFG_KP,    32'h0000_0000, 100},
        '{ROW_WORD, 2'd3, 16'h03E8, 16'h0000, CFG_KP,    32'h0000_0000, 0},
        // integral, derivative and a filtered derivative together
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KI,    32'h0000_8000, NO_WANT},
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KD,    32'h0000_4000, NO_WANT},
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_ALPHA, 32'h0000_4000, NO_WANT},
        '{ROW_WORD, 2'd0, 16'h0028, 16'h0000, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd0, 16'h0028, 16'h000A, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd0, 16'h0028, 16'h001E, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd1, 16'hFFFB, 16'h0000, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd2, 16'h003C, 16'h003C, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd0, 16'h0028, 16'h0027, CFG_KP,    32'h0000_0000, NO_WANT},
        // gain extremes, filter weight above one: integral and derivative saturate
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KP,    32'h8000_0000, NO_WANT},
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KI,    32'h7FFF_FFFF, NO_WANT},
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KD,    32'h7FFF_FFFF, NO_WANT},
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_ALPHA, 32'h0001_FFFF, NO_WANT},
        '{ROW_WORD, 2'd0, 16'h7FFF, 16'h8000, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd0, 16'h8000, 16'h7FFF, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd1, 16'h8000, 16'h7FFF, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd3, 16'h8000, 16'h7FFF, CFG_KP,    32'h0000_0000, 0},
        // opposite extremes, filter weight zero holds the old derivative
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KP,    32'h7FFF_FFFF, NO_WANT},
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KD,    32'h8000_0000, NO_WANT},
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_ALPHA, 32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd2, 16'h7FFF, 16'h8000, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd2, 16'h0000, 16'h0000, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd1, 16'h0001, 16'h0000, CFG_KP,    32'h0000_0000, NO_WANT},
        // proportional off, integral at the most negative gain
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KI,    32'h8000_0000, NO_WANT},
        '{ROW_CFG,  2'd0, 16'h0000, 16'h0000, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd0, 16'hFFFF, 16'h0000, CFG_KP,    32'h0000_0000, NO_WANT},
        '{ROW_WORD, 2'd0, 16'h0001, 16'h0000, CFG_KP,    32'h0000_0000, NO_WANT}
    };

    localparam logic [15:0] EDGE16 [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    // dut ports, inputs known from time zero
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_word          i_in_word   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_word         o_out_word;
    logic              i_cfg_we    = 1'b0;
    logic [1:0]        i_cfg_index = 2'd0;
    logic [GAIN_W-1:0] i_cfg_data  = '0;

    // predictor copy of the registers and the per-channel state
    int          kp_q, ki_q, kd_q;
    logic [16:0] alpha_q;
    int          err_hist   [CHAN_COUNT];
    int          integ_hist [CHAN_COUNT];
    int          deriv_hist [CHAN_COUNT];

    t_out_word   duty_due [$];

    // idling and long-hold controls
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asks   = 0;
    int hold_taken  = 0;
    int hold_left   = 0;

    // run statistics
    int bad_count       = 0;
    int words_sent      = 0;
    int spare_words     = 0;
    int results_checked = 0;
    int full_duty       = 0;
    int zero_duty       = 0;
    int settings_used   = 0;

    pid_duty_controller_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clamp32(input longint x);
        if (x > S32_MAX) begin
            return S32_MAX;
        end
        if (x < S32_MIN) begin
            return S32_MIN;
        end
        return x;
    endfunction

    // one control update: advances the channel state and returns the duty it drives
    function automatic logic [DUTY_W-1:0] advance_channel(input t_in_word w);
        longint err, up, ud, udf, u, integ, s, a;
        int     c;
        // unused channel numbers leave all state alone
        if (w.channel >= CHAN_COUNT) begin
            return '0;
        end
        c   = int'(w.channel);
        err = longint'($signed(w.setpoint)) - longint'($signed(w.measurement));
        up  = longint'(kp_q) * err;
        ud  = clamp32(longint'(kd_q) * (err - longint'(err_hist[c])));
        // weights above one act as one
        if (alpha_q > 17'h1_0000) begin
            a = ALPHA_ONE;
        end else begin
            a = longint'(alpha_q);
        end
        // arithmetic shift on a signed value floors
        udf = clamp32(((ALPHA_ONE - a) * longint'(deriv_hist[c]) + a * ud) >>> ALPHA_BITS);
        integ = longint'(integ_hist[c]);
        u     = up + integ + udf;
        // conditional anti-windup: hold the integral while pushing further into a rail
        if (!((u >= FULL_SCALE && err > 0) || (u <= 0 && err < 0))) begin
            integ = clamp32(integ + longint'(ki_q) * err);
        end
        integ_hist[c] = int'(integ);
        err_hist[c]   = int'(err);
        deriv_hist[c] = int'(udf);
        s = up + integ + udf;
        if (s <= 0) begin
            return '0;
        end
        if (s >= FULL_SCALE) begin
            return DUTY_W'(DUTY_MAX);
        end
        return DUTY_W'(s >>> FRAC);
    endfunction

    // offer one word, honoring the sender idle rate, and log its expected result
    task automatic push_word(input t_in_word w, input int want);
        t_out_word due;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        due.channel_out = w.channel;
        due.duty        = advance_channel(w);
        // table rows with a typed duty take it as the expectation
        if (want != NO_WANT) begin
            due.duty = DUTY_W'(want);
        end
        duty_due.push_back(due);
        words_sent++;
        if (w.channel >= CHAN_COUNT) begin
            spare_words++;
        end
        if (due.duty == DUTY_W'(DUTY_MAX)) begin
            full_duty++;
        end else if (due.duty == '0) begin
            zero_duty++;
        end
    endtask

    task automatic park_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // every result back means the block is idle: every word yields one result
    task automatic wait_drain();
        while (duty_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_KP: begin
                kp_q = int'(data);
            end
            CFG_KI: begin
                ki_q = int'(data);
            end
            CFG_KD: begin
                kd_q = int'(data);
            end
            CFG_ALPHA: begin
                alpha_q = data[16:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic choose_gains(input t_gain_style style);
        logic [31:0] g [3];
        logic [31:0] alpha_w;
        case (style)
            GAINS_EDGE: begin
                for (int k = 0; k < 3; k++) begin
                    case ($urandom_range(4))
                        0: g[k] = 32'h8000_0000;
                        1: g[k] = 32'h7FFF_FFFF;
                        2: g[k] = 32'h0000_0000;
                        3: g[k] = 32'hFFFF_FFFF;
                        default: g[k] = 32'h0001_0000;
                    endcase
                end
                case ($urandom_range(3))
                    0: alpha_w = 32'h0000_0000;
                    1: alpha_w = 32'h0001_0000;
                    2: alpha_w = 32'h0001_FFFF;
                    default: alpha_w = 32'hFFFF_FFFF;
                endcase
            end
            GAINS_WIDE: begin
                for (int k = 0; k < 3; k++) begin
                    g[k] = $urandom;
                end
                alpha_w = $urandom;
            end
            default: begin
                // plant-like gains so duty moves through its whole range
                g[0] = $urandom_range(32'h0006_0000);
                g[1] = $urandom_range(32'h0000_4000);
                g[2] = $urandom_range(32'h0002_0000);
                for (int k = 0; k < 3; k++) begin
                    if ($urandom_range(7) == 0) begin
                        g[k] = -g[k];
                    end
                end
                alpha_w = $urandom_range(32'h0001_0000);
            end
        endcase
        write_reg(CFG_KP, g[0]);
        write_reg(CFG_KI, g[1]);
        write_reg(CFG_KD, g[2]);
        write_reg(CFG_ALPHA, alpha_w);
        settings_used++;
    endtask

    task automatic report_bad(input string what, input t_out_word want, input t_out_word got);
        bad_count++;
        if (bad_count <= 10) begin
            $display("%0t: %s: expected ch %0d duty %0d, got ch %0d duty %0d", $realtime,
                     what, want.channel_out, want.duty, got.channel_out, got.duty);
        end
    endtask

    // receiver: random stall, or a long hold when asked, counted here
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_taken != hold_asks) begin
            hold_taken  <= hold_asks;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // result checker: each accepted word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (duty_due.size() == 0) begin
                report_bad("unexpected word", '0, o_out_word);
            end else begin
                want = duty_due.pop_front();
                results_checked++;
                if (want.channel_out != o_out_word.channel_out) begin
                    report_bad("channel_out mismatch", want, o_out_word);
                end else if (want.duty != o_out_word.duty) begin
                    report_bad("duty mismatch", want, o_out_word);
                end
            end
        end
    end

    // watchdog: no word moving on either side for too long means a hang
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_in_word w;
        int       dice;
        kp_q    = 0;
        ki_q    = 0;
        kd_q    = 0;
        alpha_q = 17'h1_0000;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            err_hist[c]   = 0;
            integ_hist[c] = 0;
            deriv_hist[c] = 0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under light sender idling, heavy receiver stalls
        tx_idle_pct = 35;
        rx_idle_pct = 75;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].kind == ROW_CFG) begin
                park_input();
                wait_drain();
                write_reg(DIR_TABLE[r].reg_sel, DIR_TABLE[r].reg_data);
            end else begin
                w.channel     = DIR_TABLE[r].channel;
                w.setpoint    = DIR_TABLE[r].setpoint;
                w.measurement = DIR_TABLE[r].measurement;
                push_word(w, DIR_TABLE[r].want);
            end
        end

        // random phases: new gains each time, idling swapped, then none
        for (int p = 0; p < PHASES; p++) begin
            park_input();
            wait_drain();
            if (p == 0) begin
                choose_gains(GAINS_EDGE);
            end else if (p == 1) begin
                choose_gains(GAINS_WIDE);
            end else if (p == PHASES - 1) begin
                choose_gains(t_gain_style'($urandom_range(2)));
            end else begin
                choose_gains(GAINS_TUNED);
            end
            if (p < 2) begin
                tx_idle_pct = 35;
                rx_idle_pct = 75;
            end else if (p < 4) begin
                tx_idle_pct = 75;
                rx_idle_pct = 35;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // long receiver hold with the sender still pushing, fills the block
            if (p == 4) begin
                hold_asks++;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                dice = $urandom_range(99);
                if (dice % 20 == 0) begin
                    w.channel = 2'd3;
                end else begin
                    w.channel = 2'($urandom_range(CHAN_COUNT - 1));
                end
                if (dice < 65) begin
                    // tracking a setpoint: small errors, the integral builds up
                    w.setpoint    = 16'($urandom_range(4000)) - 16'd2000;
                    w.measurement = w.setpoint - (16'($urandom_range(400)) - 16'd200);
                end else if (dice < 90) begin
                    w.setpoint    = 16'($urandom);
                    w.measurement = 16'($urandom);
                end else begin
                    w.setpoint    = EDGE16[$urandom_range(3)];
                    w.measurement = EDGE16[$urandom_range(3)];
                end
                push_word(w, NO_WANT);
            end
        end

        park_input();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d words (%0d on unused channel numbers) over %0d gain settings",
                 words_sent, spare_words, settings_used + 6);
        $display("checked %0d results: %0d at full duty, %0d at zero, %0d mismatches",
                 results_checked, full_duty, zero_duty, bad_count);
        if (bad_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
